FILE: rtl/ffsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit server loss allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int NUM_SERVERS = 16;

	localparam int OP_W     = 2;
	localparam int TIME_W   = 32;
	localparam int SERVER_W = 4;
	localparam int COUNT_W  = 32;
	localparam int SVC_W    = 24;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [SERVER_W-1:0] server_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [SVC_W-1:0]    svc_t;

	localparam op_t OP_CLEAR   = 2'd0;
	localparam op_t OP_ARRIVAL = 2'd1;
	localparam op_t OP_READ    = 2'd2;

	localparam svc_t   SVC_RESET = 24'd131072;
	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
	localparam time_t  TIME_MAX  = {TIME_W{1'b1}};

	// A request as it travels down the row of server cells.
	typedef struct packed {
		op_t     op;
		time_t   arrival_time;
		server_t server_index;
		logic    found;
		server_t server;
		count_t  count;
	} req_t;

	function automatic count_t sat_inc(input count_t v);
		sat_inc = (v == COUNT_MAX) ? v : v + count_t'(1);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ffsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_cell
// One server: holds its busy-until time and served count, updates them as a
// request passes, and hands the request to the next cell.
// ----------------------------------------------------------------------------
module ffsa_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ffsa_pkg::server_t cell_id,
	input  wire ffsa_pkg::svc_t   service_time,
	input  wire logic             up_valid,
	input  wire ffsa_pkg::req_t   up_req,
	output logic                  up_ready,
	output logic                  dn_valid,
	output ffsa_pkg::req_t        dn_req,
	input  wire logic             dn_ready
);
	import ffsa_pkg::*;

	logic             valid_q;
	req_t             req_s1;
	time_t            busy_q;
	count_t           cnt_q;
	time_t            busy_d;
	count_t           cnt_d;
	count_t           cnt_inc;
	req_t             nxt;
	logic [TIME_W:0]  end_sum;
	time_t            end_sat;
	logic             take;

	// The stage frees up when empty or when its request moves on.
	assign up_ready = !valid_q || dn_ready;
	assign take     = up_valid && up_ready;
	assign dn_valid = valid_q;
	assign dn_req   = req_s1;

	assign end_sum = {1'b0, up_req.arrival_time} + (TIME_W + 1)'(service_time);
	assign end_sat = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
	assign cnt_inc = sat_inc(cnt_q);

	always_comb begin
		nxt    = up_req;
		busy_d = busy_q;
		cnt_d  = cnt_q;
		unique case (up_req.op)
			OP_CLEAR: begin
				busy_d = '0;
				cnt_d  = '0;
			end
			OP_ARRIVAL: begin
				if (!up_req.found && (up_req.arrival_time >= busy_q)) begin
					busy_d     = end_sat;
					cnt_d      = cnt_inc;
					nxt.found  = 1'b1;
					nxt.server = cell_id;
					nxt.count  = cnt_inc;
				end
			end
			OP_READ: begin
				if (up_req.server_index == cell_id) begin
					nxt.count = cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				busy_q  <= busy_d;
				cnt_q   <= cnt_d;
			end else if (dn_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ffsa_tail.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_tail
// End of the server row: keeps the drop counter and holds the result
// register toward the output channel.
// ----------------------------------------------------------------------------
module ffsa_tail (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	input  wire ffsa_pkg::req_t   up_req,
	output logic                  up_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output logic                  served,
	output ffsa_pkg::server_t     server,
	output ffsa_pkg::count_t      serve_count,
	output ffsa_pkg::count_t      drop_count
);
	import ffsa_pkg::*;

	logic    rsp_valid_q;
	logic    served_q;
	server_t server_q;
	count_t  count_q;
	count_t  drop_q;
	count_t  dropped_q;
	count_t  dropped_d;
	logic    served_d;
	server_t server_d;
	count_t  count_d;
	logic    take;

	assign up_ready = !rsp_valid_q || !rsp_stall;
	assign take     = up_valid && up_ready;

	always_comb begin
		dropped_d = dropped_q;
		served_d  = 1'b0;
		server_d  = '0;
		count_d   = '0;
		unique case (up_req.op)
			OP_CLEAR: begin
				dropped_d = '0;
			end
			OP_ARRIVAL: begin
				if (up_req.found) begin
					served_d = 1'b1;
					server_d = up_req.server;
					count_d  = up_req.count;
				end else begin
					dropped_d = sat_inc(dropped_q);
				end
			end
			OP_READ: begin
				server_d = up_req.server_index;
				count_d  = up_req.count;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			dropped_q   <= '0;
		end else begin
			if (take) begin
				rsp_valid_q <= 1'b1;
				dropped_q   <= dropped_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			served_q <= served_d;
			server_q <= server_d;
			count_q  <= count_d;
			drop_q   <= dropped_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign served      = served_q;
	assign server      = server_q;
	assign serve_count = count_q;
	assign drop_count  = drop_q;

endmodule
`default_nettype wire

FILE: rtl/first_fit_server_loss_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_server_loss_allocator
// Loss system with a row of servers: an arrival takes the lowest-numbered
// free server or is dropped; clear and read requests share the same path.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   op, arrival_time, server_index
//   rsp       out        rsp_valid/rsp_stall   served, server, serve_count,
//                                              drop_count
//   cfg       in         cfg_wr_en             cfg_wr_data (service time)
//
// One request is taken per cycle unless stalled. A request walks the row of
// server cells, one cell per cycle unless stalled, into the tail register.
// Reset clears every timer and counter at once and loads the default service
// time; no clearing pass is needed. A stalled output holds only the stages
// behind it that are full, so empty cells keep taking requests.
// ----------------------------------------------------------------------------
module first_fit_server_loss_allocator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire ffsa_pkg::svc_t      cfg_wr_data,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire ffsa_pkg::op_t       op,
	input  wire ffsa_pkg::time_t     arrival_time,
	input  wire ffsa_pkg::server_t   server_index,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic                     served,
	output ffsa_pkg::server_t        server,
	output ffsa_pkg::count_t         serve_count,
	output ffsa_pkg::count_t         drop_count
);
	import ffsa_pkg::*;

	svc_t svc_q;
	req_t req_chain [NUM_SERVERS+1];
	logic vld_chain [NUM_SERVERS+1];
	logic rdy_chain [NUM_SERVERS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svc_q <= SVC_RESET;
		end else if (cfg_wr_en) begin
			svc_q <= cfg_wr_data;
		end
	end

	always_comb begin
		req_chain[0].op           = op;
		req_chain[0].arrival_time = arrival_time;
		req_chain[0].server_index = server_index;
		req_chain[0].found        = 1'b0;
		req_chain[0].server       = '0;
		req_chain[0].count        = '0;
	end

	assign vld_chain[0] = req_valid;
	assign req_stall    = !rdy_chain[0];

	for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
		ffsa_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_id      (server_t'(i)),
			.service_time (svc_q),
			.up_valid     (vld_chain[i]),
			.up_req       (req_chain[i]),
			.up_ready     (rdy_chain[i]),
			.dn_valid     (vld_chain[i+1]),
			.dn_req       (req_chain[i+1]),
			.dn_ready     (rdy_chain[i+1])
		);
	end

	ffsa_tail u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (vld_chain[NUM_SERVERS]),
		.up_req      (req_chain[NUM_SERVERS]),
		.up_ready    (rdy_chain[NUM_SERVERS]),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.served      (served),
		.server      (server),
		.serve_count (serve_count),
		.drop_count  (drop_count)
	);

endmodule
`default_nettype wire
